@@ rtl/opdf_pkg.sv @@
// Shared types and constants for the order-preserving dedup filter.
// Used by opdf_cell and order_preserving_dedup_filter; no dependencies.
`default_nettype none

package opdf_pkg;

	localparam int unsigned VALUE_W = 31;
	localparam int unsigned SLOT_W  = 6;
	localparam int unsigned COUNT_W = 7;

	// item moving down the cell chain
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               hit;    // resolved: matched or stored
		logic               fresh;  // stored in a cell on this pass
	} opdf_tok_t;

endpackage

`default_nettype wire

@@ rtl/opdf_cell.sv @@
// One store cell of the dedup chain: holds one distinct value and passes
// the item on to the next cell on each cycle with adv. Depends on opdf_pkg.
`default_nettype none

module opdf_cell
	import opdf_pkg::*;
#(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned SW       = 6,
	parameter int unsigned CW       = 7
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          adv,
	input  wire logic          vld_i,
	input  wire opdf_tok_t     tok_i,
	input  wire logic [SW-1:0] slot_i,
	input  wire logic [CW-1:0] cnt_i,
	output logic               vld_o,
	output opdf_tok_t          tok_o,
	output logic [SW-1:0]      slot_o,
	output logic [CW-1:0]      cnt_o
);

	logic               occ_q;
	logic [VALUE_W-1:0] stored_q;
	logic               vld_q;
	opdf_tok_t          tok_q;
	logic [SW-1:0]      slot_q;
	logic [CW-1:0]      cnt_q;

	logic open_tok;
	logic match;
	logic take;
	logic occ_after;

	assign open_tok  = vld_i && !tok_i.hit;
	assign match     = open_tok && occ_q && (stored_q == tok_i.value);
	assign take      = open_tok && !occ_q;
	assign occ_after = occ_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_i;
			if (vld_i)
				occ_q <= occ_after && !tok_i.last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (take)
				stored_q <= tok_i.value;
			tok_q.value <= tok_i.value;
			tok_q.last  <= tok_i.last;
			tok_q.hit   <= tok_i.hit || match || take;
			tok_q.fresh <= tok_i.fresh || take;
			slot_q      <= (match || take) ? SW'(CELL_IDX) : slot_i;
			cnt_q       <= cnt_i + CW'(occ_after);
		end
	end

	assign vld_o  = vld_q;
	assign tok_o  = tok_q;
	assign slot_o = slot_q;
	assign cnt_o  = cnt_q;

endmodule

`default_nettype wire

@@ rtl/order_preserving_dedup_filter.sv @@
// Top level of the order-preserving dedup filter: a chain of opdf_cell
// stages followed by an output register. Depends on opdf_pkg, opdf_cell.
`default_nettype none

// Each item walks a chain of CAPACITY cells, one cell per cycle while the
// chain advances; the first cell holding the same value reports its slot,
// and the first empty cell stores the value. The item passes through the
// register of each cell and then the output register; one item is accepted
// per cycle when the output is drained. An end-of-set item empties each
// cell as it passes, so items behind it start a new set. When the output
// stalls, the whole chain still moves on while its last cell is empty and
// halts once an item reaches it; gaps between items are kept.
module order_preserving_dedup_filter
	import opdf_pkg::*;
#(
	parameter int unsigned CAPACITY = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [30:0] sample_value, [31] zero
	input  wire logic        s_tlast,   // end_of_set
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [30:0] echo_value, [31] is_new,
	                                    // [37:32] slot_index,
	                                    // [44:38] distinct_count,
	                                    // [45] overflow, [47:46] zero
	output logic             m_tlast    // set_done
);

	localparam int unsigned SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic          vld  [CAPACITY+1];
	opdf_tok_t     tok  [CAPACITY+1];
	logic [SW-1:0] slot [CAPACITY+1];
	logic [CW-1:0] cnt  [CAPACITY+1];

	logic adv;

	logic               out_vld_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_fresh_q;
	logic               out_ovf_q;
	logic               out_last_q;
	logic [SW-1:0]      out_slot_q;
	logic [CW-1:0]      out_cnt_q;

	logic [SW+SLOT_W-1:0]  slot_ext;
	logic [CW+COUNT_W-1:0] cnt_ext;

	assign adv      = !out_vld_q || m_tready || !vld[CAPACITY];
	assign s_tready = adv;

	assign vld[0]       = s_tvalid;
	assign tok[0].value = s_tdata[VALUE_W-1:0];
	assign tok[0].last  = s_tlast;
	assign tok[0].hit   = 1'b0;
	assign tok[0].fresh = 1'b0;
	assign slot[0]      = '0;
	assign cnt[0]       = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		opdf_cell #(
			.CELL_IDX (i),
			.SW       (SW),
			.CW       (CW)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.vld_i  (vld[i]),
			.tok_i  (tok[i]),
			.slot_i (slot[i]),
			.cnt_i  (cnt[i]),
			.vld_o  (vld[i+1]),
			.tok_o  (tok[i+1]),
			.slot_o (slot[i+1]),
			.cnt_o  (cnt[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (!out_vld_q || m_tready) begin
			out_vld_q <= vld[CAPACITY];
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || m_tready) begin
			out_value_q <= tok[CAPACITY].value;
			out_fresh_q <= tok[CAPACITY].fresh;
			out_ovf_q   <= !tok[CAPACITY].hit;
			out_last_q  <= tok[CAPACITY].last;
			out_slot_q  <= slot[CAPACITY];
			out_cnt_q   <= cnt[CAPACITY];
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, out_slot_q};
	assign cnt_ext  = {{COUNT_W{1'b0}}, out_cnt_q};

	assign m_tvalid = out_vld_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {2'b00, out_ovf_q, cnt_ext[COUNT_W-1:0], slot_ext[SLOT_W-1:0],
		out_fresh_q, out_value_q};

	a_new_xor_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_fresh_q && out_ovf_q))
		else $error("item both stored and dropped");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_cnt_q <= CW'(CAPACITY)))
		else $error("distinct count above capacity");

	a_fresh_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_fresh_q) |-> (CW'(out_slot_q) + CW'(1) == out_cnt_q))
		else $error("new value not stored at the last slot");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_ovf_q) |-> (out_cnt_q == CW'(CAPACITY) && out_slot_q == '0))
		else $error("overflow with free cells");

endmodule

`default_nettype wire
